/* rtl/rrbe_pkg.sv */
// ----------------------------------------------------------------------------
// rrbe_pkg
// Shared constants and types for the retro-reflection BSDF evaluator.
// ----------------------------------------------------------------------------
package rrbe_pkg;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int DIV_BITS = 28;   // quotient bits of cos_d^2 (Q28)

    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

    typedef enum logic [1:0] {
        REG_ROUGHNESS  = 2'd0,
        REG_BASE_RED   = 2'd1,
        REG_BASE_GREEN = 2'd2,
        REG_BASE_BLUE  = 2'd3
    } rrbe_reg_t;

    // values that ride alongside the divider
    typedef struct packed {
        logic        ge;      // cos_d^2 saturates at 1.0
        logic        hzero;   // half vector is zero
        logic [30:0] fo;      // |cos out|^5, Q30
        logic [30:0] fi;      // |cos in|^5, Q30
        logic [15:0] pdf;     // finished pdf
    } rrbe_side_t;

endpackage

/* rtl/rrbe_div.sv */
// ----------------------------------------------------------------------------
// rrbe_div
// Pipelined restoring divider, one quotient bit per stage, giving
// floor(rem * 2^DIV_BITS / den) for rem < den. Side data travels along.
// ----------------------------------------------------------------------------
module rrbe_div
    import rrbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [33:0]         in_rem,
    input  logic [33:0]         in_den,
    input  rrbe_side_t          in_side,
    output logic                out_valid,
    output logic [DIV_BITS-1:0] out_quo,
    output rrbe_side_t          out_side
);

    typedef struct packed {
        logic [33:0]         rem;
        logic [33:0]         den;
        logic [DIV_BITS-1:0] quo;
        rrbe_side_t          side;
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t  r;
        logic [34:0] sh;
        logic [34:0] dv;
        r  = s;
        sh = {s.rem, 1'b0};
        dv = {1'b0, s.den};
        if (sh >= dv)
        begin
            r.rem = 34'(sh - dv);
            r.quo = {s.quo[DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[33:0];
            r.quo = {s.quo[DIV_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    div_stage_t          in_stage;
    div_stage_t          stg_reg  [DIV_BITS];
    div_stage_t          stg_next [DIV_BITS];
    logic [DIV_BITS-1:0] v_reg;

    assign in_stage = '{rem: in_rem, den: in_den, quo: '0, side: in_side};

    always_comb
    begin
        stg_next[0] = div_step(in_stage);
        for (int k = 1; k < DIV_BITS; k++)
        begin
            stg_next[k] = div_step(stg_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_BITS; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_BITS-1];
    assign out_quo   = stg_reg[DIV_BITS-1].quo;
    assign out_side  = stg_reg[DIV_BITS-1].side;

endmodule

/* rtl/retro_reflection_bsdf_eval.sv */
// ----------------------------------------------------------------------------
// retro_reflection_bsdf_eval
// Retro-reflection BSDF colour and cosine pdf for one shading sample per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries normal, outgoing and incoming
//   directions as signed Q1.15. Output channel (out_valid / out_stall) returns
//   bsdf_red/green/blue (Q2.14) and pdf_value (Q0.16), one item per input.
//   Roughness and base colour sit on the APB port at 0x0, 0x4, 0x8, 0xC;
//   change them only while no item is in flight.
//   Throughput: one item per cycle, sustained while in_stall stays low.
//   The 28-stage cos_d^2 divider makes up most of the pipeline depth.
//   Reset empties the pipeline and loads roughness 0.5 and white base colour.
//   When the receiver stalls, the output register holds its item and one more
//   item lands in a skid register; in_stall then rises until the skid drains.
//   The pipeline freezes as a whole while the skid is full, nothing is lost.
// ----------------------------------------------------------------------------
module retro_reflection_bsdf_eval
    import rrbe_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 15
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  normal_x,
    input  logic signed [15:0]  normal_y,
    input  logic signed [15:0]  normal_z,
    input  logic signed [15:0]  out_x,
    input  logic signed [15:0]  out_y,
    input  logic signed [15:0]  out_z,
    input  logic signed [15:0]  incoming_x,
    input  logic signed [15:0]  incoming_y,
    input  logic signed [15:0]  incoming_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         bsdf_red,
    output logic [15:0]         bsdf_green,
    output logic [15:0]         bsdf_blue,
    output logic [15:0]         pdf_value
);

    localparam int TWO_F = 2 * VEC_FRAC_BITS;
    localparam int SHR   = (TWO_F >= 30) ? TWO_F - 30 : 0;
    localparam int SHL   = (TWO_F < 30) ? 30 - TWO_F : 0;
    localparam logic [31:0] SAT_LIM = 32'(ONE_Q30) >> SHL;

    // magnitude of a raw dot product as Q30, saturated at 1.0
    function automatic logic [30:0] mag_q30(input logic [31:0] m);
        logic [31:0] t;
        if (TWO_F >= 30)
        begin
            t = m >> SHR;
            mag_q30 = (t > 32'(ONE_Q30)) ? ONE_Q30 : t[30:0];
        end
        else
        begin
            t = m << SHL;
            mag_q30 = (m > SAT_LIM) ? ONE_Q30 : t[30:0];
        end
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] d);
        logic signed [32:0] a;
        a = d[32] ? -d : d;
        return a[31:0];
    endfunction

    function automatic logic [15:0] round_q214(input logic [63:0] z, input logic hzero);
        logic [64:0] s;
        s = {1'b0, z} + (65'd1 << 47);
        if (hzero)
            return 16'd0;
        else if (s[64])
            return 16'hFFFF;
        else
            return s[63:48];
    endfunction

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic signed [16:0] hx;
        logic signed [16:0] hy;
        logic signed [16:0] hz;
        logic signed [32:0] dno;
        logic signed [32:0] dni;
    } s1_t;

    typedef struct packed {
        logic signed [33:0] oh;
        logic [33:0]        hh;
        logic [30:0]        cfo;
        logic [30:0]        cfi;
        logic               pdf_pos;
        logic               hzero;
    } s2_t;

    typedef struct packed {
        logic [32:0] nm;
        logic [33:0] hh;
        logic [30:0] cfo;
        logic [30:0] c2o;
        logic [30:0] cfi;
        logic [30:0] c2i;
        logic [61:0] zp;
        logic        pdf_pos;
        logic        hzero;
    } s3_t;

    typedef struct packed {
        logic [63:0] nm2;
        logic [33:0] hh;
        logic [30:0] cfo;
        logic [30:0] c4o;
        logic [30:0] cfi;
        logic [30:0] c4i;
        logic [15:0] pdf;
        logic        hzero;
    } s4_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] hh;
        rrbe_side_t  side;
    } s5_t;

    typedef struct packed {
        logic [30:0] rr;
        logic [30:0] p;
        logic [30:0] fo;
        logic [30:0] fi;
        logic        hzero;
        logic [15:0] pdf;
    } t1_t;

    typedef struct packed {
        logic [30:0] rr;
        logic        rr_ge;
        logic [30:0] pm;
        logic [31:0] sumf;
        logic        hzero;
        logic [15:0] pdf;
    } t2_t;

    typedef struct packed {
        logic [30:0] rr;
        logic [31:0] term;
        logic        hzero;
        logic [15:0] pdf;
    } t3_t;

    typedef struct packed {
        logic [32:0] x;
        logic        hzero;
        logic [15:0] pdf;
    } t4_t;

    typedef struct packed {
        logic [32:0] yr;
        logic [32:0] yg;
        logic [32:0] yb;
        logic        hzero;
        logic [15:0] pdf;
    } t5_t;

    typedef struct packed {
        logic [63:0] zr;
        logic [63:0] zg;
        logic [63:0] zb;
        logic        hzero;
        logic [15:0] pdf;
    } t6_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] pdf;
    } out_t;

    // ---------------- configuration ----------------
    logic [15:0] rough_reg;
    logic [15:0] base_r_reg;
    logic [15:0] base_g_reg;
    logic [15:0] base_b_reg;
    logic        cfg_wr;
    rrbe_reg_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = rrbe_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rough_reg  <= 16'h8000;
            base_r_reg <= 16'hFFFF;
            base_g_reg <= 16'hFFFF;
            base_b_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ROUGHNESS:  rough_reg  <= pwdata[15:0];
                REG_BASE_RED:   base_r_reg <= pwdata[15:0];
                REG_BASE_GREEN: base_g_reg <= pwdata[15:0];
                REG_BASE_BLUE:  base_b_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROUGHNESS:  prdata = DATA_W'(rough_reg);
            REG_BASE_RED:   prdata = DATA_W'(base_r_reg);
            REG_BASE_GREEN: prdata = DATA_W'(base_g_reg);
            REG_BASE_BLUE:  prdata = DATA_W'(base_b_reg);
        endcase
    end

    // ---------------- pipeline ----------------
    logic en;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic t1_v_reg, t2_v_reg, t3_v_reg, t4_v_reg, t5_v_reg, t6_v_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    t1_t  t1_reg, t1_next;
    t2_t  t2_reg, t2_next;
    t3_t  t3_reg, t3_next;
    t4_t  t4_reg, t4_next;
    t5_t  t5_reg, t5_next;
    t6_t  t6_reg, t6_next;

    logic                dv_valid;
    logic [DIV_BITS-1:0] dv_quo;
    rrbe_side_t          dv_side;

    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // dot products n.o and n.i, half vector h = o - i
    always_comb
    begin
        logic signed [31:0] pox, poy, poz, pix, piy, piz;
        pox = normal_x * out_x;
        poy = normal_y * out_y;
        poz = normal_z * out_z;
        pix = normal_x * incoming_x;
        piy = normal_y * incoming_y;
        piz = normal_z * incoming_z;
        s1_next.ox  = out_x;
        s1_next.oy  = out_y;
        s1_next.oz  = out_z;
        s1_next.hx  = {out_x[15], out_x} - {incoming_x[15], incoming_x};
        s1_next.hy  = {out_y[15], out_y} - {incoming_y[15], incoming_y};
        s1_next.hz  = {out_z[15], out_z} - {incoming_z[15], incoming_z};
        s1_next.dno = 33'(pox) + 33'(poy) + 33'(poz);
        s1_next.dni = 33'(pix) + 33'(piy) + 33'(piz);
    end

    // o.h, h.h, clamped cosines
    always_comb
    begin
        logic signed [32:0] pohx, pohy, pohz;
        logic signed [33:0] phx, phy, phz;
        pohx = $signed(s1_reg.ox) * $signed(s1_reg.hx);
        pohy = $signed(s1_reg.oy) * $signed(s1_reg.hy);
        pohz = $signed(s1_reg.oz) * $signed(s1_reg.hz);
        phx  = $signed(s1_reg.hx) * $signed(s1_reg.hx);
        phy  = $signed(s1_reg.hy) * $signed(s1_reg.hy);
        phz  = $signed(s1_reg.hz) * $signed(s1_reg.hz);
        s2_next.oh      = 34'(pohx) + 34'(pohy) + 34'(pohz);
        s2_next.hh      = 34'(phx[31:0]) + 34'(phy[31:0]) + 34'(phz[31:0]);
        s2_next.cfo     = mag_q30(abs33(s1_reg.dno));
        s2_next.cfi     = mag_q30(abs33(s1_reg.dni));
        s2_next.pdf_pos = s1_reg.dni[32] || (s1_reg.dni == '0);
        s2_next.hzero   = (s1_reg.hx == '0) && (s1_reg.hy == '0) && (s1_reg.hz == '0);
    end

    // |o.h|, cos^2, pdf product
    always_comb
    begin
        logic signed [33:0] a;
        logic [61:0]        qo, qi;
        a  = s2_reg.oh[33] ? -$signed(s2_reg.oh) : $signed(s2_reg.oh);
        qo = s2_reg.cfo * s2_reg.cfo;
        qi = s2_reg.cfi * s2_reg.cfi;
        s3_next.nm      = a[32:0];
        s3_next.hh      = s2_reg.hh;
        s3_next.cfo     = s2_reg.cfo;
        s3_next.c2o     = qo[60:30];
        s3_next.cfi     = s2_reg.cfi;
        s3_next.c2i     = qi[60:30];
        s3_next.zp      = s2_reg.cfi * INV_PI_Q32;
        s3_next.pdf_pos = s2_reg.pdf_pos;
        s3_next.hzero   = s2_reg.hzero;
    end

    // (o.h)^2 modulo 2^64, cos^4, pdf rounding
    always_comb
    begin
        logic [65:0] sq;
        logic [61:0] qo, qi, pr;
        sq = s3_reg.nm * s3_reg.nm;
        qo = s3_reg.c2o * s3_reg.c2o;
        qi = s3_reg.c2i * s3_reg.c2i;
        pr = s3_reg.zp + (62'd1 << 45);
        s4_next.nm2   = sq[63:0];
        s4_next.hh    = s3_reg.hh;
        s4_next.cfo   = s3_reg.cfo;
        s4_next.c4o   = qo[60:30];
        s4_next.cfi   = s3_reg.cfi;
        s4_next.c4i   = qi[60:30];
        s4_next.pdf   = s3_reg.pdf_pos ? pr[61:46] : 16'd0;
        s4_next.hzero = s3_reg.hzero;
    end

    // cos^5, saturation test ahead of the divider
    always_comb
    begin
        logic [61:0] qo, qi;
        qo = s4_reg.c4o * s4_reg.cfo;
        qi = s4_reg.c4i * s4_reg.cfi;
        s5_next.rem        = s4_reg.nm2[33:0];
        s5_next.hh         = s4_reg.hh;
        s5_next.side.ge    = (s4_reg.nm2 >= {30'd0, s4_reg.hh});
        s5_next.side.hzero = s4_reg.hzero;
        s5_next.side.fo    = qo[60:30];
        s5_next.side.fi    = qi[60:30];
        s5_next.side.pdf   = s4_reg.pdf;
    end

    rrbe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_rem    (s5_reg.rem),
        .in_den    (s5_reg.hh),
        .in_side   (s5_reg.side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // rr = 2 * roughness * cos_d^2, fo*fi
    always_comb
    begin
        logic [30:0] cd2;
        logic [46:0] pr;
        logic [61:0] pp;
        cd2 = dv_side.ge ? ONE_Q30 : {1'b0, dv_quo, 2'b00};
        pr  = rough_reg * cd2;
        pp  = dv_side.fo * dv_side.fi;
        t1_next.rr    = {pr[45:16], 1'b0};
        t1_next.p     = pp[60:30];
        t1_next.fo    = dv_side.fo;
        t1_next.fi    = dv_side.fi;
        t1_next.hzero = dv_side.hzero;
        t1_next.pdf   = dv_side.pdf;
    end

    // fo*fi*|rr-1|
    always_comb
    begin
        logic [30:0] d;
        logic [61:0] pp;
        d  = t1_reg.rr[30] ? (t1_reg.rr - ONE_Q30) : (ONE_Q30 - t1_reg.rr);
        pp = t1_reg.p * d;
        t2_next.rr    = t1_reg.rr;
        t2_next.rr_ge = t1_reg.rr[30];
        t2_next.pm    = pp[60:30];
        t2_next.sumf  = 32'(t1_reg.fo) + 32'(t1_reg.fi);
        t2_next.hzero = t1_reg.hzero;
        t2_next.pdf   = t1_reg.pdf;
    end

    always_comb
    begin
        t3_next.rr    = t2_reg.rr;
        t3_next.term  = t2_reg.rr_ge ? (t2_reg.sumf + 32'(t2_reg.pm))
                                     : (t2_reg.sumf - 32'(t2_reg.pm));
        t3_next.hzero = t2_reg.hzero;
        t3_next.pdf   = t2_reg.pdf;
    end

    always_comb
    begin
        logic [62:0] px;
        px = t3_reg.rr * t3_reg.term;
        t4_next.x     = px[62:30];
        t4_next.hzero = t3_reg.hzero;
        t4_next.pdf   = t3_reg.pdf;
    end

    always_comb
    begin
        logic [48:0] pr, pg, pb;
        pr = t4_reg.x * base_r_reg;
        pg = t4_reg.x * base_g_reg;
        pb = t4_reg.x * base_b_reg;
        t5_next.yr    = pr[48:16];
        t5_next.yg    = pg[48:16];
        t5_next.yb    = pb[48:16];
        t5_next.hzero = t4_reg.hzero;
        t5_next.pdf   = t4_reg.pdf;
    end

    always_comb
    begin
        t6_next.zr    = t5_reg.yr * INV_PI_Q32;
        t6_next.zg    = t5_reg.yg * INV_PI_Q32;
        t6_next.zb    = t5_reg.yb * INV_PI_Q32;
        t6_next.hzero = t5_reg.hzero;
        t6_next.pdf   = t5_reg.pdf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
            t4_v_reg <= 1'b0;
            t5_v_reg <= 1'b0;
            t6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            t1_v_reg <= dv_valid;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= t2_v_reg;
            t4_v_reg <= t3_v_reg;
            t5_v_reg <= t4_v_reg;
            t6_v_reg <= t5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            t5_reg <= t5_next;
            t6_reg <= t6_next;
        end
    end

    // ---------------- output register and skid ----------------
    out_t result;
    out_t out_reg, out_next;
    out_t skid_reg;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_next;
    logic load_skid;
    logic take;

    assign result.red   = round_q214(t6_reg.zr, t6_reg.hzero);
    assign result.green = round_q214(t6_reg.zg, t6_reg.hzero);
    assign result.blue  = round_q214(t6_reg.zb, t6_reg.hzero);
    assign result.pdf   = t6_reg.pdf;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (t6_v_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (load_skid)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bsdf_red   = out_reg.red;
    assign bsdf_green = out_reg.green;
    assign bsdf_blue  = out_reg.blue;
    assign pdf_value  = out_reg.pdf;

endmodule
